>>> hw/rtl/sbpr_pkg.sv
`default_nettype none

package sbpr_pkg;

	localparam int PIXEL_COUNT_BITS = 22;
	localparam int CNT_W            = PIXEL_COUNT_BITS + 1;
	localparam int NREG             = 3;
	localparam int IDX_W            = 2;
	localparam int PCT_W            = 15;
	localparam int NUM_W            = CNT_W + PCT_W;
	localparam int STEP_W           = $clog2(PCT_W);
	localparam int FIFO_AW          = 2;
	localparam int FIFO_DEPTH       = 1 << FIFO_AW;

	localparam int EST_W   = 16;
	localparam int TRUTH_W = 8;
	localparam int THR_W   = 12;
	localparam int GAIN_W  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONV_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

	localparam logic [THR_W-1:0]  THR_RESET  = 12'd16;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	localparam logic [PCT_W-1:0] PCT_SCALE = 15'd25600;
	localparam logic [CNT_W-1:0] CNT_LIMIT = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};

	typedef struct packed {
		logic            last;
		logic [NREG-1:0] mask;
		logic [NREG-1:0] bad;
	} item_t;

	typedef struct packed {
		logic [NREG-1:0]  bad;
		logic             totals_valid;
		logic [PCT_W-1:0] pct_all;
		logic [PCT_W-1:0] pct_nonocc;
		logic [PCT_W-1:0] pct_disc;
		logic [NREG-1:0]  empty_regions;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < CNT_LIMIT) ? v + CNT_W'(1) : CNT_LIMIT;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stereo_bad_pixel_rate.sv
// Stereo bad-pixel rate counter.
// Input queue side: present estimate, truth_value, the three region bits and
// last_pixel with push; the item is taken on a rising edge with push high and
// full low. Result queue side: while empty is low the oldest result sits on
// the result ports; pop it with pop high. Each pixel yields one result with
// its three bad flags.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 threshold,
// 1 conversion enable, 2 gain) on the edge; write only while the block is idle.
// Ordinary pixels pass the front register, the queue and the result register,
// one pixel per cycle while no stall holds them. The last pixel of an image
// adds the three percentages, worked out one after another by a shared
// restoring divider of 15 steps. Pixels behind it wait in the four-entry
// queue between front and back and stall input once that queue and the
// front register are full.
// A stalled result holds on the ports; the back stops and the front keeps
// taking pixels until the queue and its own register are full, then raises full.
// Reset clears the counters, loads the register defaults and empties both
// queues.
`default_nettype none

module stereo_bad_pixel_rate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic signed [sbpr_pkg::EST_W-1:0] estimate,
	input  logic [sbpr_pkg::TRUTH_W-1:0]      truth_value,
	input  logic                              in_all,
	input  logic                              in_nonocc,
	input  logic                              in_disc,
	input  logic                              last_pixel,
	input  logic                              pop,
	output logic                              empty,
	output logic                              bad_all,
	output logic                              bad_nonocc,
	output logic                              bad_disc,
	output logic                              totals_valid,
	output logic [sbpr_pkg::PCT_W-1:0]        pct_all,
	output logic [sbpr_pkg::PCT_W-1:0]        pct_nonocc,
	output logic [sbpr_pkg::PCT_W-1:0]        pct_disc,
	output logic [sbpr_pkg::NREG-1:0]         empty_regions
);
	import sbpr_pkg::*;

	logic    fifo_full;
	logic    fifo_push;
	logic    fifo_empty;
	logic    fifo_pop;
	item_t   push_item;
	item_t   head_item;
	result_t result;

	sbpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.estimate    (estimate),
		.truth_value (truth_value),
		.in_all      (in_all),
		.in_nonocc   (in_nonocc),
		.in_disc     (in_disc),
		.last_pixel  (last_pixel),
		.fifo_full   (fifo_full),
		.fifo_push   (fifo_push),
		.fifo_item   (push_item)
	);

	sbpr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (fifo_push),
		.wr_item    (push_item),
		.fifo_full  (fifo_full),
		.rd_en      (fifo_pop),
		.rd_item    (head_item),
		.fifo_empty (fifo_empty)
	);

	sbpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_item  (head_item),
		.fifo_pop   (fifo_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign bad_all       = result.bad[0];
	assign bad_nonocc    = result.bad[1];
	assign bad_disc      = result.bad[2];
	assign totals_valid  = result.totals_valid;
	assign pct_all       = result.pct_all;
	assign pct_nonocc    = result.pct_nonocc;
	assign pct_disc      = result.pct_disc;
	assign empty_regions = result.empty_regions;

endmodule

`default_nettype wire

>>> hw/rtl/sbpr_front.sv
`default_nettype none

module sbpr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic signed [sbpr_pkg::EST_W-1:0] estimate,
	input  logic [sbpr_pkg::TRUTH_W-1:0]      truth_value,
	input  logic                              in_all,
	input  logic                              in_nonocc,
	input  logic                              in_disc,
	input  logic                              last_pixel,
	input  logic                              fifo_full,
	output logic                              fifo_push,
	output sbpr_pkg::item_t                   fifo_item
);
	import sbpr_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic              conv_en_q;
	logic [GAIN_W-1:0] gain_q;

	logic                               valid_s1;
	logic signed [EST_W+GAIN_W:0]       prod_s1;
	logic signed [EST_W-1:0]            est_s1;
	logic [TRUTH_W-1:0]                 truth_s1;
	logic [NREG-1:0]                    mask_s1;
	logic                               last_s1;

	logic                               accept;
	logic signed [EST_W+GAIN_W+1:0]     rnd;
	logic [TRUTH_W-1:0]                 conv8;
	logic signed [EST_W:0]              eff;
	logic signed [EST_W:0]              diff;
	logic [EST_W:0]                     adiff;
	logic                               over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			conv_en_q <= 1'b0;
			gain_q    <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				CFG_CONV_EN:   conv_en_q <= cfg_data[0];
				CFG_GAIN:      gain_q    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign full      = valid_s1 && fifo_full;
	assign accept    = push && !full;
	assign fifo_push = valid_s1 && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fifo_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1  <= (EST_W+GAIN_W+1)'(estimate)
			          * (EST_W+GAIN_W+1)'($signed({1'b0, gain_q}));
			est_s1   <= estimate;
			truth_s1 <= truth_value;
			mask_s1  <= {in_disc, in_nonocc, in_all};
			last_s1  <= last_pixel;
		end
	end

	always_comb begin
		rnd = {prod_s1[EST_W+GAIN_W], prod_s1} + (EST_W+GAIN_W+2)'(128);
		if (rnd[EST_W+GAIN_W+1]) begin
			conv8 = '0;
		end else if (|rnd[EST_W+GAIN_W:TRUTH_W+8]) begin
			conv8 = '1;
		end else begin
			conv8 = rnd[TRUTH_W+7:8];
		end
		eff   = conv_en_q ? $signed({{(EST_W+1-TRUTH_W){1'b0}}, conv8})
		                  : $signed({est_s1[EST_W-1], est_s1});
		diff  = eff - $signed({{(EST_W+1-TRUTH_W){1'b0}}, truth_s1});
		adiff = diff[EST_W] ? (EST_W+1)'(-diff) : (EST_W+1)'(diff);
		over  = {adiff, 4'b0000} > (EST_W+5)'(thr_q);
	end

	assign fifo_item.last = last_s1;
	assign fifo_item.mask = mask_s1;
	assign fifo_item.bad  = mask_s1 & {NREG{over}};

endmodule

`default_nettype wire

>>> hw/rtl/sbpr_fifo.sv
`default_nettype none

module sbpr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  sbpr_pkg::item_t wr_item,
	output logic            fifo_full,
	input  logic            rd_en,
	output sbpr_pkg::item_t rd_item,
	output logic            fifo_empty
);
	import sbpr_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign fifo_full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign fifo_empty = count_q == '0;
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sbpr_div.sv
`default_nettype none

module sbpr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sbpr_pkg::CNT_W-1:0]   pix_n,
	input  logic [sbpr_pkg::CNT_W-1:0]   bad_n,
	output logic                         done,
	output logic [sbpr_pkg::PCT_W-1:0]   quot
);
	import sbpr_pkg::*;

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [PCT_W-1:0]  quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  num;
	logic              fits;

	assign num  = NUM_W'(bad_n) * NUM_W'(PCT_SCALE) + NUM_W'(pix_n >> 1);
	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PCT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'(pix_n) << (PCT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[PCT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/sbpr_back.sv
`default_nettype none

module sbpr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fifo_empty,
	input  sbpr_pkg::item_t   fifo_item,
	output logic              fifo_pop,
	input  logic              pop,
	output logic              empty,
	output sbpr_pkg::result_t result
);
	import sbpr_pkg::*;

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_START = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_EMIT  = 4'b1000
	} back_state_t;

	back_state_t       state_q;
	logic [CNT_W-1:0]  pix_q    [NREG];
	logic [CNT_W-1:0]  bad_q    [NREG];
	logic [CNT_W-1:0]  snap_n_q [NREG];
	logic [CNT_W-1:0]  snap_b_q [NREG];
	logic [CNT_W-1:0]  pix_nx   [NREG];
	logic [CNT_W-1:0]  bad_nx   [NREG];
	logic [PCT_W-1:0]  pct_q    [NREG];
	logic [NREG-1:0]   empty_q;
	logic [NREG-1:0]   flags_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic              take;
	logic              emit;
	logic              div_start;
	logic              div_done;
	logic [PCT_W-1:0]  div_quot;
	logic              reg_empty;
	logic [PCT_W-1:0]  pct_val;

	assign out_free  = !out_valid_q || pop;
	assign take      = (state_q == ST_RUN) && !fifo_empty && out_free;
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign fifo_pop  = take;
	assign div_start = state_q == ST_START;
	assign reg_empty = snap_n_q[idx_q] == '0;
	assign pct_val   = reg_empty ? '0 : ((div_quot > PCT_SCALE) ? PCT_SCALE : div_quot);

	always_comb begin
		for (int i = 0; i < NREG; i++) begin
			pix_nx[i] = fifo_item.mask[i] ? sat_inc(pix_q[i]) : pix_q[i];
			bad_nx[i] = fifo_item.bad[i]  ? sat_inc(bad_q[i]) : bad_q[i];
		end
	end

	sbpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.pix_n  (snap_n_q[idx_q]),
		.bad_n  (snap_b_q[idx_q]),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NREG; i++) begin
				pix_q[i] <= '0;
				bad_q[i] <= '0;
			end
		end else begin
			if ((take && !fifo_item.last) || emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (take) begin
						for (int i = 0; i < NREG; i++) begin
							pix_q[i] <= fifo_item.last ? '0 : pix_nx[i];
							bad_q[i] <= fifo_item.last ? '0 : bad_nx[i];
						end
						if (fifo_item.last) begin
							idx_q   <= '0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						if (idx_q == IDX_W'(NREG - 1)) begin
							state_q <= ST_EMIT;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (fifo_item.last) begin
				flags_q <= fifo_item.bad;
				for (int i = 0; i < NREG; i++) begin
					snap_n_q[i] <= pix_nx[i];
					snap_b_q[i] <= bad_nx[i];
				end
			end else begin
				out_q.bad           <= fifo_item.bad;
				out_q.totals_valid  <= 1'b0;
				out_q.pct_all       <= '0;
				out_q.pct_nonocc    <= '0;
				out_q.pct_disc      <= '0;
				out_q.empty_regions <= '0;
			end
		end
		if ((state_q == ST_WAIT) && div_done) begin
			pct_q[idx_q]   <= pct_val;
			empty_q[idx_q] <= reg_empty;
		end
		if (emit) begin
			out_q.bad           <= flags_q;
			out_q.totals_valid  <= 1'b1;
			out_q.pct_all       <= pct_q[0];
			out_q.pct_nonocc    <= pct_q[1];
			out_q.pct_disc      <= pct_q[2];
			out_q.empty_regions <= empty_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/sbpr_checker.sv
`default_nettype none

module sbpr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop,
	input  logic                              empty,
	input  logic                              bad_all,
	input  logic                              bad_nonocc,
	input  logic                              bad_disc,
	input  logic                              totals_valid,
	input  logic [sbpr_pkg::PCT_W-1:0]        pct_all,
	input  logic [sbpr_pkg::PCT_W-1:0]        pct_nonocc,
	input  logic [sbpr_pkg::PCT_W-1:0]        pct_disc,
	input  logic [sbpr_pkg::NREG-1:0]         empty_regions
);
	import sbpr_pkg::*;

	a_totals_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !totals_valid) |->
		(pct_all == '0 && pct_nonocc == '0 && pct_disc == '0 && empty_regions == '0))
		else $error("totals fields set on an ordinary item");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pct_all <= PCT_SCALE && pct_nonocc <= PCT_SCALE && pct_disc <= PCT_SCALE))
		else $error("percentage above full scale");

	a_empty_region: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && totals_valid && empty_regions[0]) |-> (pct_all == '0 && !bad_all))
		else $error("empty region reports bad pixels");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pct_all) && $stable(totals_valid)
		&& $stable(bad_all) && $stable(bad_nonocc) && $stable(bad_disc)))
		else $error("stalled item changed");

endmodule

bind stereo_bad_pixel_rate sbpr_checker u_sbpr_checker (.*);

`default_nettype wire
